/* sv/rit_pkg.sv */
`default_nettype none

package rit_pkg;

  localparam int DIV_W      = 32;
  localparam int BASE_W     = 7;
  localparam int DIGIT_W    = 6;
  localparam int CHAR_W     = 8;
  localparam int NUM_WORDS  = 8;
  localparam int WORD_W     = 64;
  localparam int CFG_IDX_W  = 4;
  localparam int SCAN_CNT_W = 7;

  localparam logic [CHAR_W-1:0] MINUS_CHAR = 8'd45;
  localparam logic [CHAR_W-1:0] ERR_CHAR   = 8'd0;

  typedef struct packed {
    logic              done;
    logic              invalid;
    logic [BASE_W-1:0] base;
  } rit_scan_res_t;

  typedef struct packed {
    logic              done;
    logic [DIV_W-1:0]  quot;
    logic [BASE_W-1:0] rem;
  } rit_div_res_t;

  function automatic logic is_alnum(input logic [CHAR_W-1:0] c);
    return (c > 8'd47 && c < 8'd58) || (c > 8'd64 && c < 8'd91) ||
           (c > 8'd96 && c < 8'd123);
  endfunction

endpackage

`default_nettype wire

/* sv/rit_ram.sv */
`default_nettype none

module rit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* sv/rit_div.sv */
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module rit_div (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [rit_pkg::DIV_W-1:0]  dividend,
  input  wire logic [rit_pkg::BASE_W-1:0] divisor,
  output rit_pkg::rit_div_res_t           res
);

  localparam int CNT_W = $clog2(rit_pkg::DIV_W + 1);

  logic [CNT_W-1:0]           count_r, count_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [rit_pkg::DIV_W-1:0]  quo_r, quo_nxt;
  logic [rit_pkg::BASE_W-1:0] rem_r, rem_nxt;
  logic [rit_pkg::BASE_W:0]   trial;
  logic [rit_pkg::BASE_W:0]   diff;

  assign trial = {rem_r, quo_r[rit_pkg::DIV_W-1]};
  assign diff  = trial - {1'b0, divisor};

  always_comb begin
    count_nxt = count_r;
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    quo_nxt   = quo_r;
    rem_nxt   = rem_r;
    if (start) begin
      count_nxt = CNT_W'(rit_pkg::DIV_W);
      busy_nxt  = 1'b1;
      quo_nxt   = dividend;
      rem_nxt   = '0;
    end else if (busy_r) begin
      // The partial remainder always stays below the divisor, so it fits BASE_W bits.
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = diff[rit_pkg::BASE_W-1:0];
        quo_nxt = {quo_r[rit_pkg::DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[rit_pkg::BASE_W-1:0];
        quo_nxt = {quo_r[rit_pkg::DIV_W-2:0], 1'b0};
      end
      count_nxt = count_r - CNT_W'(1);
      if (count_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      busy_r  <= 1'b0;
      done_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      busy_r  <= busy_nxt;
      done_r  <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign res.done = done_r;
  assign res.quot = quo_r;
  assign res.rem  = rem_r;

endmodule

`default_nettype wire

/* sv/rit_scan.sv */
`default_nettype none

// Walks the alphabet one character a cycle, counting the leading alphanumeric
// run and flagging a repeat through a bitmap of characters already seen.
module rit_scan #(
  parameter int LIMIT = 64
) (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       start,
  input  wire logic [rit_pkg::CHAR_W-1:0] char_in,
  output logic [rit_pkg::DIGIT_W-1:0]     idx,
  output rit_pkg::rit_scan_res_t          res
);

  logic [rit_pkg::SCAN_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                           busy_r, busy_nxt;
  logic                           done_r, done_nxt;
  logic                           invalid_r, invalid_nxt;
  logic [rit_pkg::BASE_W-1:0]     base_r, base_nxt;
  logic [127:0]                   seen_r, seen_nxt;
  logic                           at_end;

  assign at_end = (cnt_r == rit_pkg::SCAN_CNT_W'(LIMIT));
  assign idx    = cnt_r[rit_pkg::DIGIT_W-1:0];

  always_comb begin
    cnt_nxt     = cnt_r;
    busy_nxt    = busy_r;
    done_nxt    = 1'b0;
    invalid_nxt = invalid_r;
    base_nxt    = base_r;
    seen_nxt    = seen_r;
    if (start) begin
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
      seen_nxt = '0;
    end else if (busy_r) begin
      if (at_end || !rit_pkg::is_alnum(char_in)) begin
        busy_nxt    = 1'b0;
        done_nxt    = 1'b1;
        base_nxt    = rit_pkg::BASE_W'(cnt_r);
        invalid_nxt = (cnt_r < rit_pkg::SCAN_CNT_W'(2));
      end else if (seen_r[char_in[6:0]]) begin
        busy_nxt    = 1'b0;
        done_nxt    = 1'b1;
        invalid_nxt = 1'b1;
      end else begin
        seen_nxt[char_in[6:0]] = 1'b1;
        cnt_nxt = cnt_r + rit_pkg::SCAN_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      busy_r    <= 1'b0;
      done_r    <= 1'b0;
      invalid_r <= 1'b0;
      base_r    <= '0;
      seen_r    <= '0;
    end else begin
      cnt_r     <= cnt_nxt;
      busy_r    <= busy_nxt;
      done_r    <= done_nxt;
      invalid_r <= invalid_nxt;
      base_r    <= base_nxt;
      seen_r    <= seen_nxt;
    end
  end

  assign res.done    = done_r;
  assign res.invalid = invalid_r;
  assign res.base    = base_r;

endmodule

`default_nettype wire

/* sv/radix_integer_to_text.sv */
`default_nettype none

// Channel  Direction  Ports                                         Handshake
// in       input      in_value                                      in_valid / in_stall
// out      output     out_char, out_is_last, out_base_invalid       out_valid / out_stall
// cfg      input      cfg_index, cfg_data                           cfg_we
//
// Each request first scans the alphabet, then runs the shared divider once per digit,
// then emits the characters through the digit RAM. in_stall is high from acceptance
// until the last character is in the output register. Reset is synchronous and clears
// control state and the alphabet registers. A stalled output holds its register and
// pauses character emission.
module radix_integer_to_text #(
  parameter int MAX_DIGITS     = 32,
  parameter int ALPHABET_CHARS = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [rit_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rit_pkg::WORD_W-1:0]    cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [31:0]            in_value,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [rit_pkg::CHAR_W-1:0]         out_char,
  output logic                               out_is_last,
  output logic                               out_base_invalid
);

  localparam int AW   = $clog2(MAX_DIGITS);
  localparam int ND_W = $clog2(MAX_DIGITS + 1);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_SCAN = 7'b0000010,
    ST_ERR  = 7'b0000100,
    ST_DIV  = 7'b0001000,
    ST_SIGN = 7'b0010000,
    ST_RD   = 7'b0100000,
    ST_EMIT = 7'b1000000
  } state_t;

  state_t                                         state_r, state_nxt;
  logic [rit_pkg::NUM_WORDS-1:0][rit_pkg::WORD_W-1:0] alpha_r;
  logic                                           neg_r, neg_nxt;
  logic [rit_pkg::DIV_W-1:0]                      mag_r, mag_nxt;
  logic [ND_W-1:0]                                nd_r, nd_nxt;
  logic [AW-1:0]                                  ptr_r, ptr_nxt;
  logic                                           out_valid_r, out_valid_nxt;
  logic [rit_pkg::CHAR_W-1:0]                     out_char_r, out_char_nxt;
  logic                                           out_last_r, out_last_nxt;
  logic                                           out_bad_r, out_bad_nxt;

  logic                          in_accept;
  logic                          out_free;
  logic                          load;
  logic [rit_pkg::DIV_W-1:0]     raw;
  logic                          scan_start;
  logic [rit_pkg::DIGIT_W-1:0]   scan_idx;
  rit_pkg::rit_scan_res_t        scan_res;
  logic                          div_start;
  rit_pkg::rit_div_res_t         div_res;
  logic [rit_pkg::DIGIT_W-1:0]   char_idx;
  logic [rit_pkg::CHAR_W-1:0]    alpha_char;
  logic                          ram_we;
  logic [rit_pkg::DIGIT_W-1:0]   ram_rdata;
  logic [ND_W-1:0]               nd_after;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign raw       = in_value;

  // The alphabet is read at one place only: the scan index, or the stored digit.
  assign char_idx   = (state_r == ST_SCAN) ? scan_idx : ram_rdata;
  assign alpha_char = alpha_r[char_idx[5:3]][char_idx[2:0]*8 +: 8];

  assign scan_start = in_accept;
  assign nd_after   = (nd_r < ND_W'(MAX_DIGITS)) ? nd_r + ND_W'(1) : nd_r;

  rit_scan #(
    .LIMIT(ALPHABET_CHARS)
  ) u_scan (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (scan_start),
    .char_in(alpha_char),
    .idx    (scan_idx),
    .res    (scan_res)
  );

  rit_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(mag_nxt),
    .divisor (scan_res.base),
    .res     (div_res)
  );

  rit_ram #(
    .WIDTH(rit_pkg::DIGIT_W),
    .DEPTH(MAX_DIGITS)
  ) u_digits (
    .clk  (clk),
    .we   (ram_we),
    .waddr(nd_r[AW-1:0]),
    .wdata(div_res.rem[rit_pkg::DIGIT_W-1:0]),
    .raddr(ptr_r),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_nxt    = state_r;
    neg_nxt      = neg_r;
    mag_nxt      = mag_r;
    nd_nxt       = nd_r;
    ptr_nxt      = ptr_r;
    div_start    = 1'b0;
    ram_we       = 1'b0;
    load         = 1'b0;
    out_char_nxt = out_char_r;
    out_last_nxt = out_last_r;
    out_bad_nxt  = out_bad_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          neg_nxt   = raw[rit_pkg::DIV_W-1];
          mag_nxt   = raw[rit_pkg::DIV_W-1] ? (32'd0 - raw) : raw;
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_res.done) begin
          if (scan_res.invalid) begin
            state_nxt = ST_ERR;
          end else begin
            nd_nxt    = '0;
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          // Digits past the store depth are dropped; only the low ones are kept.
          ram_we = (nd_r < ND_W'(MAX_DIGITS));
          nd_nxt = nd_after;
          if (div_res.quot != '0) begin
            mag_nxt   = div_res.quot;
            div_start = 1'b1;
          end else begin
            ptr_nxt   = AW'(nd_after - ND_W'(1));
            state_nxt = neg_r ? ST_SIGN : ST_RD;
          end
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          load         = 1'b1;
          out_char_nxt = rit_pkg::MINUS_CHAR;
          out_last_nxt = 1'b0;
          out_bad_nxt  = 1'b0;
          state_nxt    = ST_RD;
        end
      end
      ST_RD: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          load         = 1'b1;
          out_char_nxt = alpha_char;
          out_last_nxt = (ptr_r == '0);
          out_bad_nxt  = 1'b0;
          if (ptr_r == '0) begin
            state_nxt = ST_IDLE;
          end else begin
            ptr_nxt   = ptr_r - AW'(1);
            state_nxt = ST_RD;
          end
        end
      end
      ST_ERR: begin
        if (out_free) begin
          load         = 1'b1;
          out_char_nxt = rit_pkg::ERR_CHAR;
          out_last_nxt = 1'b1;
          out_bad_nxt  = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    out_valid_nxt = load ? 1'b1 : (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      alpha_r     <= '0;
      nd_r        <= '0;
      ptr_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      nd_r        <= nd_nxt;
      ptr_r       <= ptr_nxt;
      if (cfg_we && cfg_index < rit_pkg::CFG_IDX_W'(rit_pkg::NUM_WORDS)) begin
        alpha_r[cfg_index[2:0]] <= cfg_data;
      end
    end
    neg_r      <= neg_nxt;
    mag_r      <= mag_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
    out_bad_r  <= out_bad_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_char         = out_char_r;
  assign out_is_last      = out_last_r;
  assign out_base_invalid = out_bad_r;

endmodule

`default_nettype wire

/* bench/tb_radix_integer_to_text.sv */
`default_nettype none

module tb_radix_integer_to_text;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SCAN_CHARS     = 64;
  localparam int POOL_CHARS     = 62;
  localparam int ITEM_COUNT     = 310;
  localparam int HOLD_CYCLES    = 400;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 20000;

  localparam logic signed [31:0] MOST_NEGATIVE = 32'sh8000_0000;
  localparam logic signed [31:0] MOST_POSITIVE = 32'sh7fff_ffff;

  typedef struct packed {
    logic [rit_pkg::CHAR_W-1:0] ch;
    logic                       last;
    logic                       bad;
  } text_char_t;

  class text_scoreboard;
    logic [rit_pkg::WORD_W-1:0] alphabet [rit_pkg::NUM_WORDS];
    text_char_t                 pending_chars [$];
    int                         failures;

    function new();
      foreach (alphabet[i]) alphabet[i] = '0;
      failures = 0;
    endfunction

    static function bit is_digit_char(logic [rit_pkg::CHAR_W-1:0] c);
      return c inside {[8'd48:8'd57], [8'd65:8'd90], [8'd97:8'd122]};
    endfunction

    function void write_word(int idx, logic [rit_pkg::WORD_W-1:0] data);
      if (idx < rit_pkg::NUM_WORDS) alphabet[idx] = data;
    endfunction

    function logic [rit_pkg::CHAR_W-1:0] char_at(int i);
      return alphabet[i / 8][(i % 8) * 8 +: 8];
    endfunction

    // Zero means the alphabet cannot be used as a base.
    function int radix();
      int n;
      n = 0;
      while (n < SCAN_CHARS && is_digit_char(char_at(n))) n++;
      if (n < 2) return 0;
      for (int i = 1; i < n; i++)
        for (int j = 0; j < i; j++)
          if (char_at(i) == char_at(j)) return 0;
      return n;
    endfunction

    function void spell_value(logic signed [31:0] value);
      logic [31:0] mag;
      logic [31:0] base_u;
      logic [rit_pkg::DIGIT_W-1:0] digits [32];
      int nd;
      int radix_n;
      radix_n = radix();
      if (radix_n == 0) begin
        pending_chars.push_back('{ch: rit_pkg::ERR_CHAR, last: 1'b1, bad: 1'b1});
        return;
      end
      base_u = radix_n;
      mag = value;
      if (value[31]) mag = 32'd0 - mag;
      nd = 0;
      do begin
        digits[nd] = rit_pkg::DIGIT_W'(mag % base_u);
        nd++;
        mag = mag / base_u;
      end while (mag != 0);
      if (value[31])
        pending_chars.push_back('{ch: rit_pkg::MINUS_CHAR, last: 1'b0, bad: 1'b0});
      for (int i = nd - 1; i >= 0; i--)
        pending_chars.push_back('{ch: char_at(digits[i]), last: (i == 0), bad: 1'b0});
    endfunction

    function void check_char(logic [rit_pkg::CHAR_W-1:0] ch, logic last, logic bad);
      text_char_t want;
      if (pending_chars.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected character %0d last %0b invalid %0b with nothing pending",
                   ch, last, bad);
        return;
      end
      want = pending_chars.pop_front();
      if (want.ch !== ch || want.last !== last || want.bad !== bad) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: expected char %0d last %0b invalid %0b, got char %0d last %0b invalid %0b",
                   want.ch, want.last, want.bad, ch, last, bad);
      end
    endfunction
  endclass

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          cfg_we = 1'b0;
  logic [rit_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [rit_pkg::WORD_W-1:0]    cfg_data = '0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic signed [31:0]            in_value = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [rit_pkg::CHAR_W-1:0]    out_char;
  logic                          out_is_last;
  logic                          out_base_invalid;

  text_scoreboard sb = new();

  bit   calm = 1'b0;
  bit   hold_req = 1'b0;
  bit   hold_taken = 1'b0;
  int   hold_left = 0;
  int   stall_left = 0;
  int   rx_gap;
  int   idle_cycles = 0;
  int   sent = 0;
  logic [7:0] alpha_bytes [SCAN_CHARS];
  logic [7:0] pool [POOL_CHARS];
  string alnum_pool = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";

  radix_integer_to_text dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_value         (in_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_char         (out_char),
    .out_is_last      (out_is_last),
    .out_base_invalid (out_base_invalid)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Mostly short gaps, now and then a long one; none at all in calm phases.
  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req && !hold_taken && out_valid) begin
      // Sit on a waiting character long enough for the sender to back up.
      hold_taken <= 1'b1;
      hold_left  <= HOLD_CYCLES - 1;
      out_stall  <= 1'b1;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      rx_gap = pick_gap();
      out_stall <= (rx_gap > 0);
      if (rx_gap > 0) stall_left <= rx_gap - 1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      sb.check_char(out_char, out_is_last, out_base_invalid);
  end

  initial begin
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || cfg_we || (in_valid && !in_stall) || (out_valid && !out_stall))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("radix_integer_to_text test failed");
    $finish;
  end

  // The byte after the alphabet ends the scan; the rest is random filler.
  task automatic fill_tail(int n);
    logic [7:0] b;
    if (n < SCAN_CHARS) begin
      do b = $urandom_range(0, 255); while (text_scoreboard::is_digit_char(b));
      alpha_bytes[n] = b;
    end
    for (int i = n + 1; i < SCAN_CHARS; i++) alpha_bytes[i] = $urandom_range(0, 255);
  endtask

  task automatic load_alphabet();
    logic [rit_pkg::WORD_W-1:0]    word;
    logic [rit_pkg::CFG_IDX_W-1:0] idx;
    while (sb.pending_chars.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    for (int w = 0; w < rit_pkg::NUM_WORDS; w++) begin
      for (int k = 0; k < 8; k++) word[k * 8 +: 8] = alpha_bytes[w * 8 + k];
      cfg_we    <= 1'b1;
      cfg_index <= rit_pkg::CFG_IDX_W'(w);
      cfg_data  <= word;
      sb.write_word(w, word);
      @(negedge clk);
    end
    if ($urandom_range(0, 1)) begin
      // Indexes past the last word must leave the alphabet alone.
      idx  = $urandom_range(rit_pkg::NUM_WORDS, 15);
      word = {$urandom, $urandom};
      cfg_index <= idx;
      cfg_data  <= word;
      sb.write_word(idx, word);
      @(negedge clk);
    end
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  task automatic load_text(string s);
    for (int i = 0; i < s.len(); i++) alpha_bytes[i] = s[i];
    fill_tail(s.len());
    load_alphabet();
  endtask

  // Called at a falling edge; returns at the falling edge after the request
  // is taken, with valid still high so the next request can follow at once.
  task automatic send_value(logic signed [31:0] v);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_value <= v;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.spell_value(v);
    sent++;
    @(negedge clk);
  endtask

  initial begin
    int kind;
    int n;
    int count;
    int i1;
    int j1;
    int radix_n;
    logic [7:0] t;
    logic signed [31:0] v;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // The alphabet comes out of reset empty, so only the error item appears.
    send_value(0);
    send_value(-1);
    in_valid <= 1'b0;

    load_text("01");
    send_value(MOST_NEGATIVE);
    send_value(MOST_POSITIVE);
    send_value(0);
    send_value(-1);
    send_value(1);
    in_valid <= 1'b0;

    load_text("0123456789");
    send_value(0);
    send_value(MOST_NEGATIVE);
    send_value(MOST_POSITIVE);
    send_value(-1);
    send_value(1234567890);
    in_valid <= 1'b0;

    load_text(alnum_pool);
    send_value(MOST_NEGATIVE);
    send_value(MOST_POSITIVE);
    send_value(61);
    send_value(62);
    send_value(-62);
    in_valid <= 1'b0;

    // A single usable character is rejected rather than looping.
    load_text("A");
    send_value(5);
    in_valid <= 1'b0;

    load_text("0120");
    send_value(7);
    in_valid <= 1'b0;

    // Every scanned character is alphanumeric, so some must repeat.
    for (int i = 0; i < SCAN_CHARS; i++) alpha_bytes[i] = alnum_pool[i % POOL_CHARS];
    load_alphabet();
    send_value(9);
    in_valid <= 1'b0;

    hold_req <= 1'b1;
    while (sent < ITEM_COUNT) begin
      calm <= ($urandom_range(0, 3) == 0);
      for (int i = 0; i < POOL_CHARS; i++) pool[i] = alnum_pool[i];
      for (int i = POOL_CHARS - 1; i > 0; i--) begin
        j1 = $urandom_range(0, i);
        t = pool[i];
        pool[i] = pool[j1];
        pool[j1] = t;
      end
      kind = $urandom_range(0, 99);
      if (kind < 94) begin
        if (kind < 10) n = 2;
        else if (kind < 20) n = POOL_CHARS;
        else if (kind < 70) n = $urandom_range(3, 16);
        else if (kind < 80) n = $urandom_range(17, POOL_CHARS - 1);
        else if (kind < 86) n = $urandom_range(0, 1);
        else n = $urandom_range(2, 20);
        for (int i = 0; i < n; i++) alpha_bytes[i] = pool[i];
        if (kind >= 86) begin
          i1 = $urandom_range(1, n - 1);
          j1 = $urandom_range(0, i1 - 1);
          alpha_bytes[i1] = alpha_bytes[j1];
        end
        fill_tail(n);
      end else begin
        for (int i = 0; i < SCAN_CHARS; i++)
          alpha_bytes[i] = pool[$urandom_range(0, POOL_CHARS - 1)];
      end
      load_alphabet();

      radix_n = sb.radix();
      count = $urandom_range(8, 30);
      for (int k = 0; k < count && sent < ITEM_COUNT; k++) begin
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
          case ($urandom_range(0, 7))
            0: v = 0;
            1: v = 1;
            2: v = -1;
            3: v = MOST_NEGATIVE;
            4: v = MOST_POSITIVE;
            5: v = radix_n - 1;
            6: v = radix_n;
            default: v = -radix_n;
          endcase
        end else if (kind < 45) begin
          v = $urandom;
        end else begin
          v = $urandom >> $urandom_range(0, 31);
          if ($urandom_range(0, 1)) v = -v;
        end
        send_value(v);
      end
      in_valid <= 1'b0;
    end

    while (sb.pending_chars.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.failures == 0 && sb.pending_chars.size() == 0)
      $display("radix_integer_to_text test passed");
    else
      $display("radix_integer_to_text test failed");
    $finish;
  end

endmodule

`default_nettype wire

/* sim.f */
sv/rit_pkg.sv
sv/rit_ram.sv
sv/rit_div.sv
sv/rit_scan.sv
sv/radix_integer_to_text.sv
bench/tb_radix_integer_to_text.sv
